[hdl/apq_pkg.sv]
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types, constants and helpers for the quantized average pooling block.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int MAX_SIDE   = 256;
  localparam int MAX_FILTER = 8;

  localparam int SIDE_W     = 9;                       // 1..256 needs 9 bits
  localparam int POS_W      = $clog2(MAX_SIDE);        // 8
  localparam int FILT_W     = 4;
  localparam int FROW_W     = $clog2(MAX_FILTER);      // 3
  localparam int LINE_DEPTH = MAX_FILTER * MAX_SIDE;   // 2048
  localparam int ADDR_W     = $clog2(LINE_DEPTH);      // 11
  localparam int ACC_W      = 15;                      // -8192..8128
  localparam int DIV_BITS   = 14;                      // magnitude up to 8192
  localparam int AREA_W     = 7;                       // up to 64
  localparam int CFG_W      = 9;
  localparam int IDX_W      = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_SIDE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [IDX_W-1:0] REG_FILTER_ROWS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FILTER_COLS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_STRIDE        = 3'd4;

  // register reset values
  localparam logic [SIDE_W-1:0] RST_IMAGE_SIDE    = 9'd8;
  localparam logic [SIDE_W-1:0] RST_CHANNEL_COUNT = 9'd1;
  localparam logic [FILT_W-1:0] RST_FILTER_ROWS   = 4'd2;
  localparam logic [FILT_W-1:0] RST_FILTER_COLS   = 4'd2;
  localparam logic [FILT_W-1:0] RST_STRIDE        = 4'd2;

  localparam logic [2:0] CODE_MAX = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  // floor(6*x/255) for x in 0..255
  function automatic logic [2:0] quant_code(input logic [7:0] x);
    logic [10:0] p;
    logic [2:0]  k;
    begin
      p = 11'(x) * 11'd6;
      k = 3'd0;
      if (p >= 11'd255)  k = 3'd1;
      if (p >= 11'd510)  k = 3'd2;
      if (p >= 11'd765)  k = 3'd3;
      if (p >= 11'd1020) k = 3'd4;
      if (p >= 11'd1275) k = 3'd5;
      if (p >= 11'd1530) k = 3'd6;
      return k;
    end
  endfunction

endpackage

[hdl/apq_div.sv]
// ----------------------------------------------------------------------------
// apq_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apq_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [apq_pkg::DIV_BITS-1:0]      dividend,
  input  logic [apq_pkg::AREA_W-1:0]        divisor,
  output logic                              busy,
  output logic                              done,
  output logic [apq_pkg::DIV_BITS-1:0]      quotient
);

  logic [apq_pkg::DIV_BITS-1:0]         quo;
  logic [apq_pkg::AREA_W-1:0]           rem;
  logic [apq_pkg::AREA_W-1:0]           dsr;
  logic [$clog2(apq_pkg::DIV_BITS)-1:0] cnt;
  logic [apq_pkg::AREA_W:0]             rem_sh;
  logic [apq_pkg::AREA_W:0]             rem_sub;
  logic                                 fits;

  always_comb begin
    rem_sh  = {rem, quo[apq_pkg::DIV_BITS-1]};
    rem_sub = rem_sh - {1'b0, dsr};
    fits    = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(apq_pkg::DIV_BITS))'(apq_pkg::DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[apq_pkg::DIV_BITS-2:0], fits};
      rem <= fits ? rem_sub[apq_pkg::AREA_W-1:0] : rem_sh[apq_pkg::AREA_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

[hdl/average_pool_quantized_top.sv]
// ----------------------------------------------------------------------------
// average_pool_quantized_top
// Streaming int8 2-D average pooling with a 0..6 output code.
// ----------------------------------------------------------------------------
// A sample that completes no window is only written to the line store. One
// that completes a window starts the sequencer: the window is read back from
// the line store one entry per cycle, then its sum is divided by the window
// area in a shared bit-serial divider. sample_ready is high only while the
// sequencer is idle; one finished result is held in the output register
// while the next sample is taken. A write to any of the five defined
// registers restarts the stream at channel 0, row 0, col 0.
module average_pool_quantized_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [apq_pkg::IDX_W-1:0]    cfg_index,
  input  logic [apq_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         sample_valid,
  output logic                         sample_ready,
  input  logic signed [7:0]            sample,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [2:0]                   pooled_code,
  output logic [7:0]                   out_row,
  output logic [7:0]                   out_col,
  output logic [7:0]                   out_channel,
  output logic                         last
);

  localparam int PW = apq_pkg::POS_W;
  localparam int SW = apq_pkg::SIDE_W;
  localparam int FW = apq_pkg::FILT_W;
  localparam int RW = apq_pkg::FROW_W;

  // configuration
  logic [SW-1:0] image_side, channel_count;
  logic [FW-1:0] filter_rows, filter_cols, stride;
  logic [SW-1:0] side_eff, chans_eff;
  logic [FW-1:0] fr_eff, fc_eff, st_eff;

  // stream position
  logic [PW-1:0] row_pos, col_pos, channel_pos;
  logic [FW-1:0] row_phase, col_phase;
  logic [PW-1:0] row_idx, col_idx;

  logic [PW-1:0] new_col, new_row;
  logic          col_wrap, row_wrap;
  logic          produce, win_last;

  // window read-back
  apq_pkg::state_t state, state_next;
  logic [RW-1:0]  rd_row, rd_dr;
  logic [RW-1:0]  rd_dc;
  logic [PW-1:0]  rd_col, base_col;
  logic           rd_last;
  logic           q_valid;
  logic [7:0]     rd_q;
  logic [apq_pkg::ADDR_W-1:0] rd_addr;
  logic signed [apq_pkg::ACC_W-1:0] acc;

  // captured window info
  logic [PW-1:0] cap_row, cap_col, cap_ch;
  logic          cap_last;

  // sequencer controls
  logic take, rd_en, div_start, load_out;

  // divider
  logic [apq_pkg::ACC_W-1:0]    acc_mag;
  logic [apq_pkg::AREA_W-1:0]   area;
  logic [7:0]                   area_full;
  logic                         div_busy, div_done;
  logic [apq_pkg::DIV_BITS-1:0] quot;
  logic [7:0]                   x_val;

  logic [7:0] line_store [apq_pkg::LINE_DEPTH];

  // ---------------------------------------------------------------- config
  always_comb begin
    if (image_side == '0) side_eff = SW'(1);
    else if (image_side > SW'(apq_pkg::MAX_SIDE)) side_eff = SW'(apq_pkg::MAX_SIDE);
    else side_eff = image_side;

    if (channel_count == '0) chans_eff = SW'(1);
    else if (channel_count > SW'(apq_pkg::MAX_SIDE)) chans_eff = SW'(apq_pkg::MAX_SIDE);
    else chans_eff = channel_count;

    if (filter_rows == '0) fr_eff = FW'(1);
    else if (filter_rows > FW'(apq_pkg::MAX_FILTER)) fr_eff = FW'(apq_pkg::MAX_FILTER);
    else fr_eff = filter_rows;

    if (filter_cols == '0) fc_eff = FW'(1);
    else if (filter_cols > FW'(apq_pkg::MAX_FILTER)) fc_eff = FW'(apq_pkg::MAX_FILTER);
    else fc_eff = filter_cols;

    st_eff = (stride == '0) ? FW'(1) : stride;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side    <= apq_pkg::RST_IMAGE_SIDE;
      channel_count <= apq_pkg::RST_CHANNEL_COUNT;
      filter_rows   <= apq_pkg::RST_FILTER_ROWS;
      filter_cols   <= apq_pkg::RST_FILTER_COLS;
      stride        <= apq_pkg::RST_STRIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        apq_pkg::REG_IMAGE_SIDE:    image_side    <= cfg_data;
        apq_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data;
        apq_pkg::REG_FILTER_ROWS:   filter_rows   <= cfg_data[FW-1:0];
        apq_pkg::REG_FILTER_COLS:   filter_cols   <= cfg_data[FW-1:0];
        apq_pkg::REG_STRIDE:        stride        <= cfg_data[FW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- position
  always_comb begin
    col_wrap = ({1'b0, col_pos} + SW'(1)) >= side_eff;
    row_wrap = ({1'b0, row_pos} + SW'(1)) >= side_eff;
    new_col  = col_wrap ? '0 : col_pos + 1'b1;
    new_row  = row_wrap ? '0 : row_pos + 1'b1;
    // phase counters track (pos+1-filter) mod stride, so zero phase is aligned
    produce  = (({1'b0, row_pos} + SW'(1)) >= SW'(fr_eff)) &&
               (({1'b0, col_pos} + SW'(1)) >= SW'(fc_eff)) &&
               (row_phase == '0) && (col_phase == '0);
    // last aligned origin when one more stride would not fit
    win_last = (({1'b0, channel_pos} + SW'(1)) >= chans_eff) &&
               (({1'b0, row_pos} + SW'(st_eff)) >= side_eff) &&
               (({1'b0, col_pos} + SW'(st_eff)) >= side_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos     <= '0;
      col_pos     <= '0;
      channel_pos <= '0;
      row_phase   <= '0;
      col_phase   <= '0;
      row_idx     <= '0;
      col_idx     <= '0;
    end else if (cfg_we) begin
      if (cfg_index == apq_pkg::REG_IMAGE_SIDE || cfg_index == apq_pkg::REG_CHANNEL_COUNT ||
          cfg_index == apq_pkg::REG_FILTER_ROWS || cfg_index == apq_pkg::REG_FILTER_COLS ||
          cfg_index == apq_pkg::REG_STRIDE) begin
        row_pos     <= '0;
        col_pos     <= '0;
        channel_pos <= '0;
        row_phase   <= '0;
        col_phase   <= '0;
        row_idx     <= '0;
        col_idx     <= '0;
      end
    end else if (take) begin
      col_pos <= new_col;
      if (({1'b0, new_col} + SW'(1)) <= SW'(fc_eff)) begin
        col_phase <= '0;
        col_idx   <= '0;
      end else if (col_phase + 1'b1 == st_eff) begin
        col_phase <= '0;
        col_idx   <= col_idx + 1'b1;
      end else begin
        col_phase <= col_phase + 1'b1;
      end
      if (col_wrap) begin
        row_pos <= new_row;
        if (({1'b0, new_row} + SW'(1)) <= SW'(fr_eff)) begin
          row_phase <= '0;
          row_idx   <= '0;
        end else if (row_phase + 1'b1 == st_eff) begin
          row_phase <= '0;
          row_idx   <= row_idx + 1'b1;
        end else begin
          row_phase <= row_phase + 1'b1;
        end
        if (row_wrap) begin
          if (({1'b0, channel_pos} + SW'(1)) >= chans_eff) begin
            channel_pos <= '0;
          end else begin
            channel_pos <= channel_pos + 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    rd_last = (rd_dc == RW'(fc_eff - 1'b1)) && (rd_dr == RW'(fr_eff - 1'b1));
  end

  always_comb begin
    state_next = state;
    case (state)
      apq_pkg::ST_IDLE:     if (sample_valid && produce) state_next = apq_pkg::ST_SUM;
      apq_pkg::ST_SUM:      if (rd_last) state_next = apq_pkg::ST_DRAIN;
      apq_pkg::ST_DRAIN:    state_next = apq_pkg::ST_DIV_GO;
      apq_pkg::ST_DIV_GO:   state_next = apq_pkg::ST_DIV_WAIT;
      apq_pkg::ST_DIV_WAIT: if (div_done) state_next = apq_pkg::ST_EMIT;
      apq_pkg::ST_EMIT:     if (!result_valid || result_ready) state_next = apq_pkg::ST_IDLE;
      default:              state_next = apq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    rd_en        = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    case (state)
      apq_pkg::ST_IDLE:   sample_ready = 1'b1;
      apq_pkg::ST_SUM:    rd_en        = 1'b1;
      apq_pkg::ST_DIV_GO: div_start    = 1'b1;
      apq_pkg::ST_EMIT:   load_out     = !result_valid || result_ready;
      default: ;
    endcase
  end

  assign take = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= apq_pkg::ST_IDLE;
      q_valid <= 1'b0;
    end else begin
      state   <= state_next;
      q_valid <= rd_en;
    end
  end

  // window walk: rows of the line store wrap mod MAX_FILTER
  always_ff @(posedge clk) begin
    if (take) begin
      base_col <= col_pos + 1'b1 - PW'(fc_eff);
      rd_row   <= RW'(row_pos + 1'b1 - PW'(fr_eff));
      rd_col   <= col_pos + 1'b1 - PW'(fc_eff);
      rd_dr    <= '0;
      rd_dc    <= '0;
      cap_row  <= row_idx;
      cap_col  <= col_idx;
      cap_ch   <= channel_pos;
      cap_last <= win_last;
    end else if (rd_en) begin
      if (rd_dc == RW'(fc_eff - 1'b1)) begin
        rd_dc  <= '0;
        rd_col <= base_col;
        rd_dr  <= rd_dr + 1'b1;
        rd_row <= rd_row + 1'b1;
      end else begin
        rd_dc  <= rd_dc + 1'b1;
        rd_col <= rd_col + 1'b1;
      end
    end
  end

  assign rd_addr = {rd_row, rd_col};

  // line store
  always_ff @(posedge clk) begin
    if (take) begin
      line_store[{row_pos[RW-1:0], col_pos}] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= line_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc <= '0;
    end else if (q_valid) begin
      acc <= acc + {{(apq_pkg::ACC_W-8){rd_q[7]}}, rd_q};
    end
  end

  // ---------------------------------------------------------------- divide
  always_comb begin
    acc_mag   = acc[apq_pkg::ACC_W-1] ? 15'(-acc) : 15'(acc);
    area_full = 8'(fr_eff) * 8'(fc_eff);
    area      = area_full[apq_pkg::AREA_W-1:0];
    // truncated average plus 128, always 0..255
    x_val     = acc[apq_pkg::ACC_W-1] ? (8'd128 - quot[7:0]) : (8'd128 + quot[7:0]);
  end

  apq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_mag[apq_pkg::DIV_BITS-1:0]),
    .divisor  (area),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pooled_code <= apq_pkg::quant_code(x_val);
      out_row     <= cap_row;
      out_col     <= cap_col;
      out_channel <= cap_ch;
      last        <= cap_last;
    end
  end

`ifndef ASSERT_OFF
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pooled_code <= apq_pkg::CODE_MAX)
    else $error("pooled code out of range");

  a_pos_in_map: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, row_pos} < side_eff) && ({1'b0, col_pos} < side_eff))
    else $error("stream position outside map");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == apq_pkg::ST_SUM |-> ({1'b0, rd_dr} < fr_eff) && ({1'b0, rd_dc} < fc_eff))
    else $error("window walk past filter");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == apq_pkg::ST_DIV_WAIT && div_done |=> state == apq_pkg::ST_EMIT)
    else $error("quotient not taken");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quantized average pooling block. Streams int8
// samples over a range of map, window and stride settings, predicts every
// pooled window in the bench and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int              HALF_PERIOD   = 6;
  localparam int              SETTLE_CYCLES = 100;     // window read + divide + margin
  localparam int              RANDOM_ITEMS  = 1000;
  localparam int              CYCLE_LIMIT   = 3000000;
  localparam logic [apq_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [2:0] code;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] chan;
    logic       fin;
  } pool_window_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [apq_pkg::IDX_W-1:0] cfg_index = '0;
  logic [apq_pkg::CFG_W-1:0] cfg_data = '0;
  logic             sample_valid = 1'b0;
  logic             sample_ready;
  logic signed [7:0] sample = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic [2:0]       pooled_code;
  logic [7:0]       out_row;
  logic [7:0]       out_col;
  logic [7:0]       out_channel;
  logic             out_last;

  // bench copy of the pooling state
  logic [7:0]       line_copy [0:apq_pkg::LINE_DEPTH-1];
  logic [8:0]       side_reg = apq_pkg::RST_IMAGE_SIDE;
  logic [8:0]       chan_reg = apq_pkg::RST_CHANNEL_COUNT;
  logic [3:0]       frow_reg = apq_pkg::RST_FILTER_ROWS;
  logic [3:0]       fcol_reg = apq_pkg::RST_FILTER_COLS;
  logic [3:0]       stride_reg = apq_pkg::RST_STRIDE;
  int unsigned      row_pos = 0;
  int unsigned      col_pos = 0;
  int unsigned      chan_pos = 0;

  pool_window_t     pending_windows [$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               ready_hold = 0;
  bit               no_idle = 1'b0;

  average_pool_quantized_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pooled_code  (pooled_code),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_channel  (out_channel),
    .last         (out_last)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic int unsigned eff_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void apply_reg(input logic [apq_pkg::IDX_W-1:0] idx,
                                    input int unsigned val);
    case (idx)
      apq_pkg::REG_IMAGE_SIDE:    side_reg = val[8:0];
      apq_pkg::REG_CHANNEL_COUNT: chan_reg = val[8:0];
      apq_pkg::REG_FILTER_ROWS:   frow_reg = val[3:0];
      apq_pkg::REG_FILTER_COLS:   fcol_reg = val[3:0];
      apq_pkg::REG_STRIDE:        stride_reg = val[3:0];
      default:                    return;
    endcase
    row_pos = 0;
    col_pos = 0;
    chan_pos = 0;
  endfunction

  function automatic void predict_pool_window(input logic [7:0] v);
    int unsigned  side, chans, fr, fc, st, r, c, r0, c0, orow, ocol;
    int           sum, avg, x;
    logic signed [7:0] px;
    pool_window_t w;
    side  = eff_reg(side_reg, apq_pkg::MAX_SIDE);
    chans = eff_reg(chan_reg, apq_pkg::MAX_SIDE);
    fr    = eff_reg(frow_reg, apq_pkg::MAX_FILTER);
    fc    = eff_reg(fcol_reg, apq_pkg::MAX_FILTER);
    st    = eff_reg(stride_reg, 15);
    r     = row_pos % apq_pkg::MAX_SIDE;
    c     = col_pos % apq_pkg::MAX_SIDE;
    line_copy[(r % apq_pkg::MAX_FILTER) * apq_pkg::MAX_SIDE + c] = v;
    if (r + 1 >= fr && c + 1 >= fc) begin
      r0 = r + 1 - fr;
      c0 = c + 1 - fc;
      if (r0 % st == 0 && c0 % st == 0) begin
        sum = 0;
        for (int unsigned rr = r0; rr <= r; rr++) begin
          for (int unsigned cc = c0; cc <= c; cc++) begin
            px = line_copy[(rr % apq_pkg::MAX_FILTER) * apq_pkg::MAX_SIDE +
                           (cc % apq_pkg::MAX_SIDE)];
            sum += px;
          end
        end
        avg  = sum / int'(fr * fc);   // truncates toward zero
        x    = avg + 128;
        orow = r0 / st;
        ocol = c0 / st;
        w.code = 3'((6 * x) / 255);
        w.row  = orow[7:0];
        w.col  = ocol[7:0];
        w.chan = chan_pos[7:0];
        w.fin  = (chan_pos + 1 >= chans && side >= fr && side >= fc &&
                  orow == (side - fr) / st && ocol == (side - fc) / st);
        pending_windows.push_back(w);
      end
    end
    col_pos = c + 1;
    if (col_pos >= side) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= side) begin
        row_pos = 0;
        chan_pos = chan_pos + 1;
        if (chan_pos >= chans) chan_pos = 0;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_sample(input logic [7:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample <= v;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    predict_pool_window(v);
  endtask

  // stop sending, let every window come out and the sequencer settle
  task automatic drain_windows;
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high so back-to-back writes need one assignment per edge
  task automatic write_reg(input logic [apq_pkg::IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[apq_pkg::CFG_W-1:0];
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic end_writes;
    cfg_we <= 1'b0;
  endtask

  task automatic program_pool(input int unsigned side, input int unsigned chans,
                              input int unsigned fr, input int unsigned fc,
                              input int unsigned st);
    write_reg(apq_pkg::REG_IMAGE_SIDE, side);
    write_reg(apq_pkg::REG_CHANNEL_COUNT, chans);
    write_reg(apq_pkg::REG_FILTER_ROWS, fr);
    write_reg(apq_pkg::REG_FILTER_COLS, fc);
    write_reg(apq_pkg::REG_STRIDE, st);
    end_writes();
  endtask

  task automatic test_code_extremes;
    drain_windows();
    program_pool(2, 1, 2, 2, 1);
    repeat (4) push_sample(8'h80);
    repeat (4) push_sample(8'h7f);
  endtask

  // -87/2 must give -43 (code 2), flooring would give -44 (code 1)
  task automatic test_truncation;
    drain_windows();
    program_pool(2, 1, 1, 2, 1);
    push_sample(-8'sd44);
    push_sample(-8'sd43);
  endtask

  task automatic test_zero_registers;
    drain_windows();
    program_pool(0, 0, 0, 0, 0);
    push_sample(-8'sd43);
    push_sample(8'sd42);
  endtask

  task automatic test_oversize_registers;
    drain_windows();
    // filters clamp to 8, larger than a 3x3 map: nothing completes
    program_pool(3, 1, 9, 12, 1);
    repeat (3) push_sample(8'($urandom_range(0, 255)));
    drain_windows();
    program_pool(300, 300, 1, 1, 15);
    push_sample(8'sd100);
    push_sample(-8'sd100);
  endtask

  task automatic test_stream_restart;
    drain_windows();
    program_pool(2, 2, 2, 2, 1);
    push_sample(8'sd10);
    push_sample(8'sd20);
    drain_windows();
    // unknown index must not move the raster position
    write_reg(REG_UNUSED, 9'h1ff);
    end_writes();
    push_sample(8'sd30);
    push_sample(8'sd40);
    push_sample(-8'sd5);
    push_sample(-8'sd6);
    drain_windows();
    write_reg(apq_pkg::REG_STRIDE, 1);
    end_writes();
    repeat (8) push_sample(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_sample(input int mode, input int base);
    int v;
    case (mode)
      6:       return ($urandom_range(0, 1) != 0) ? 8'h7f : 8'h80;
      7: begin
        v = base + int'($urandom_range(0, 6)) - 3;
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        return 8'(v);
      end
      8:       return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(100, 127))
                                                  : 8'($urandom_range(128, 156));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_random_frames;
    int unsigned sel, side, chans, fr, fc, st, es, ec, fmax, full, n;
    int          mode, base, sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_windows();
      no_idle = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 19);
      if (sel < 16)      side = $urandom_range(1, 10);
      else if (sel < 18) side = $urandom_range(11, 40);
      else if (sel == 18) side = 0;
      else               side = $urandom_range(257, 511);
      es = eff_reg(side, apq_pkg::MAX_SIDE);
      if ($urandom_range(0, 9) == 0) chans = ($urandom_range(0, 1) != 0) ? 0
                                             : $urandom_range(257, 511);
      else chans = $urandom_range(1, 3);
      ec = eff_reg(chans, apq_pkg::MAX_SIDE);
      fmax = (es > 40) ? 2 : ((es < apq_pkg::MAX_FILTER) ? es : apq_pkg::MAX_FILTER);
      fr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, fmax);
      fc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, fmax);
      st = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      // stray upper data bits must be dropped by the narrow registers
      if ($urandom_range(0, 3) == 0) fr |= $urandom_range(0, 31) << 4;
      if ($urandom_range(0, 3) == 0) fc |= $urandom_range(0, 31) << 4;
      if ($urandom_range(0, 3) == 0) st |= $urandom_range(0, 31) << 4;
      // unknown index ahead of the real writes, ignored by the block
      if ($urandom_range(0, 7) == 0)
        write_reg(3'($urandom_range(5, 7)), $urandom_range(0, 511));
      program_pool(side, chans, fr, fc, st);
      full = es * es * ec;
      if (full <= 300)
        n = full + (($urandom_range(0, 3) == 0) ? $urandom_range(1, es * es) : 0);
      else if (es < 100)
        n = $urandom_range(es * 2, 300);
      else
        n = $urandom_range(es, es * 3);
      mode = $urandom_range(0, 8);
      base = int'($urandom_range(0, 255)) - 128;
      for (int unsigned i = 0; i < n; i++) push_sample(pick_sample(mode, base));
      sent += n;
    end
    no_idle = 1'b0;
  endtask

  // result side backpressure
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
    end else if (!result_ready || no_idle) begin
      result_ready <= 1'b1;
      ready_hold = $urandom_range(0, 8);
    end else begin
      result_ready <= 1'b0;
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin : check_windows
    pool_window_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_windows.size() == 0) begin
        report_mismatch("result with nothing expected, code", pooled_code, -1);
      end else begin
        want = pending_windows.pop_front();
        if (pooled_code !== want.code) report_mismatch("pooled_code", pooled_code, want.code);
        if (out_row !== want.row)      report_mismatch("out_row", out_row, want.row);
        if (out_col !== want.col)      report_mismatch("out_col", out_col, want.col);
        if (out_channel !== want.chan) report_mismatch("out_channel", out_channel, want.chan);
        if (out_last !== want.fin)     report_mismatch("last", out_last, want.fin);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("average_pool_quantized_top: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_code_extremes();
    test_truncation();
    test_zero_registers();
    test_oversize_registers();
    test_stream_restart();
    test_random_frames();
    drain_windows();
    if (mismatch_count == 0) begin
      $display("average_pool_quantized_top: match");
    end else begin
      $display("average_pool_quantized_top: mismatch");
    end
    $finish;
  end

endmodule
